[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion helper macros for the constant weight encoder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define CWE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// antecedent in this cycle implies consequent in the next
`define CWE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cwe_pkg.sv]
// ----------------------------------------------------------------------------
// cwe_pkg
// shared constants, register codes and controller/datapath handshake types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cwe_pkg;

  localparam int MAX_LENGTH_DEF = 64;
  localparam int DATA_W         = 64;
  localparam int CFG_W          = 7;
  localparam int CFG_AW         = 1;

  localparam logic [CFG_AW-1:0] REG_CODE_LENGTH = 1'b0;
  localparam logic [CFG_AW-1:0] REG_WEIGHT      = 1'b1;

  localparam logic [CFG_W-1:0] CODE_LENGTH_RST = 7'd64;
  localparam logic [CFG_W-1:0] WEIGHT_RST      = 7'd2;

  typedef struct packed {
    logic fill;
    logic load;
    logic check;
    logic step;
    logic emit;
  } cwe_cmd_t;

  typedef struct packed {
    logic fill_done;
    logic ovf;
    logic trivial;
    logic last;
    logic out_free;
  } cwe_stat_t;

endpackage

[rtl/cwe_in_if.sv]
// ----------------------------------------------------------------------------
// cwe_in_if
// input stream channel: number to encode
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cwe_in_if;
  logic                      valid;
  logic                      ready;
  logic [cwe_pkg::DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[rtl/cwe_out_if.sv]
// ----------------------------------------------------------------------------
// cwe_out_if
// result stream channel: code word and overflow flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cwe_out_if;
  logic                      valid;
  logic                      ready;
  logic [cwe_pkg::DATA_W-1:0] code_word;
  logic                      overflow;

  modport source (output valid, output code_word, output overflow, input ready);
  modport sink   (input valid, input code_word, input overflow, output ready);
endinterface

[rtl/cwe_ctrl.sv]
// ----------------------------------------------------------------------------
// cwe_ctrl
// sequencer: table fill after reset, then accept, range check, one bit
// position per cycle, and hand-off to the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cwe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cwe_pkg::cwe_stat_t  stat,
  output cwe_pkg::cwe_cmd_t   cmd
);
  import cwe_pkg::*;

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_CHECK,
    S_RUN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    cmd       = '0;
    cmd.fill  = (state_r == S_FILL);
    cmd.load  = in_valid && in_ready_r;
    cmd.check = (state_r == S_CHECK);
    cmd.step  = (state_r == S_RUN);
    cmd.emit  = (state_r == S_DONE) && stat.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_FILL: begin
        if (stat.fill_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.load) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.ovf || stat.trivial) state_nxt = S_DONE;
        else                          state_nxt = S_RUN;
      end
      S_RUN: begin
        if (stat.last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_FILL;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  `CWE_ASSERT(a_ready_idle, in_ready_r |-> (state_r == S_IDLE), "ready outside idle")
  `CWE_ASSERT_NEXT(a_run_exit, state_r == S_RUN, (state_r == S_RUN) || (state_r == S_DONE),
                   "run left to a state other than done")
  `CWE_ASSERT_NEXT(a_fill_once, state_r != S_FILL, state_r != S_FILL, "table fill re-entered")

endmodule

[rtl/cwe_dp.sv]
// ----------------------------------------------------------------------------
// cwe_dp
// datapath: config registers, binomial table memory with its fill sweep,
// remainder/word registers and the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cwe_dp #(
  parameter int MAX_LENGTH = cwe_pkg::MAX_LENGTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [cwe_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [cwe_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [cwe_pkg::DATA_W-1:0]   in_value,
  input  cwe_pkg::cwe_cmd_t            cmd,
  output cwe_pkg::cwe_stat_t           stat,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [cwe_pkg::DATA_W-1:0]   out_code_word,
  output logic                         out_overflow
);
  import cwe_pkg::*;

  localparam int ROW   = MAX_LENGTH + 1;
  localparam int DEPTH = ROW * ROW;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(ROW);
  localparam logic [PW-1:0]    P_MAX = PW'(MAX_LENGTH);
  localparam logic [CFG_W-1:0] L_MAX = CFG_W'(MAX_LENGTH);

  // row-major index of C(n, k)
  function automatic logic [AW-1:0] tab_addr(input logic [PW-1:0] n, input logic [PW-1:0] k);
    tab_addr = AW'(ROW) * AW'(n) + AW'(k);
  endfunction

  // config
  logic [CFG_W-1:0] code_length_r, weight_r;

  // binomial table
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] dout_a_r, dout_b_r;
  logic [AW-1:0]     rd_a, rd_b;
  logic [DATA_W-1:0] wdata;

  // fill sweep
  logic [PW-1:0] fn_r, fk_r;
  logic          iss_done_r;
  logic          wr_v_r, wr_last_r, wr_one_r, wr_zero_r;
  logic [AW-1:0] wr_addr_r;
  logic          fill_done_r;

  // item state
  logic [PW-1:0]     p_r;
  logic [CFG_W-1:0]  k_r;
  logic [DATA_W-1:0] rem_r, word_r;
  logic              sel_b_r, wide_r, res_ovf_r;

  // output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_word_r;
  logic              out_ovf_r;

  logic [PW-1:0]     n_sat, pm1, k_lo, km1;
  logic              k_big;
  logic [DATA_W-1:0] c_sel, diff;
  logic              borrow, take;

  assign n_sat = (code_length_r > L_MAX) ? P_MAX : code_length_r[PW-1:0];
  assign k_big = (weight_r > CFG_W'(n_sat));
  assign pm1   = (p_r == '0) ? '0 : p_r - 1'b1;
  assign k_lo  = k_r[PW-1:0];
  assign km1   = (k_lo == '0) ? '0 : k_lo - 1'b1;

  // sel_b_r picks the binomial that matches the previous decision
  assign c_sel          = sel_b_r ? dout_b_r : dout_a_r;
  assign {borrow, diff} = {1'b0, rem_r} - {1'b0, c_sel};
  assign take           = !borrow;

  always_comb begin
    stat           = '0;
    stat.fill_done = fill_done_r;
    stat.ovf       = wide_r || take;
    stat.trivial   = (p_r == '0) || (k_r == '0);
    stat.last      = (p_r == '0) || (take && (k_r == CFG_W'(1)));
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    rd_a = '0;
    rd_b = '0;
    if (cmd.fill) begin
      if ((fn_r != '0) && (fk_r != '0)) rd_a = tab_addr(fn_r - 1'b1, fk_r - 1'b1);
      if (fn_r != '0)                   rd_b = tab_addr(fn_r - 1'b1, fk_r);
    end else if (cmd.load) begin
      if (!k_big) rd_a = tab_addr(n_sat, weight_r[PW-1:0]);
    end else if (cmd.check || cmd.step) begin
      // prefetch both candidates for the next position
      rd_a = tab_addr(pm1, k_lo);
      rd_b = tab_addr(pm1, km1);
    end
  end

  // pascal recurrence; row zero and column zero are seeded
  assign wdata = wr_one_r  ? DATA_W'(1) :
                 wr_zero_r ? '0 : dout_a_r + dout_b_r;

  always_ff @(posedge clk) begin
    if (wr_v_r) mem[wr_addr_r] <= wdata;
    dout_a_r <= mem[rd_a];
    dout_b_r <= mem[rd_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_length_r <= CODE_LENGTH_RST;
      weight_r      <= WEIGHT_RST;
      fn_r          <= '0;
      fk_r          <= '0;
      iss_done_r    <= 1'b0;
      wr_v_r        <= 1'b0;
      fill_done_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_CODE_LENGTH: code_length_r <= cfg_wdata;
          REG_WEIGHT:      weight_r      <= cfg_wdata;
        endcase
      end

      wr_v_r <= 1'b0;
      if (cmd.fill && !iss_done_r) begin
        wr_v_r <= 1'b1;
        if (fk_r == P_MAX) begin
          fk_r <= '0;
          if (fn_r == P_MAX) iss_done_r <= 1'b1;
          else               fn_r       <= fn_r + 1'b1;
        end else begin
          fk_r <= fk_r + 1'b1;
        end
      end
      fill_done_r <= fill_done_r || (wr_v_r && wr_last_r);

      if (cmd.emit)      out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= tab_addr(fn_r, fk_r);
    wr_one_r  <= (fk_r == '0);
    wr_zero_r <= (fn_r == '0);
    wr_last_r <= (fn_r == P_MAX) && (fk_r == P_MAX);

    if (cmd.load) begin
      p_r       <= n_sat;
      k_r       <= weight_r;
      rem_r     <= in_value;
      word_r    <= '0;
      sel_b_r   <= 1'b0;
      wide_r    <= k_big;
      res_ovf_r <= 1'b0;
    end else if (cmd.check) begin
      res_ovf_r <= stat.ovf;
      p_r       <= pm1;
      sel_b_r   <= 1'b0;
    end else if (cmd.step) begin
      p_r     <= pm1;
      sel_b_r <= take;
      if (take) begin
        rem_r  <= diff;
        k_r    <= k_r - 1'b1;
        word_r <= word_r | (DATA_W'(1) << p_r);
      end
    end

    if (cmd.emit) begin
      out_word_r <= word_r;
      out_ovf_r  <= res_ovf_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_code_word = out_word_r;
  assign out_overflow  = out_ovf_r;

  `CWE_ASSERT(a_step_has_ones, cmd.step |-> (k_r != '0), "step with no ones left to place")
  `CWE_ASSERT(a_ovf_zero, (out_valid_r && out_ovf_r) |-> (out_word_r == '0),
              "overflow result carries a nonzero word")
  `CWE_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_r, "emitted result not presented")

endmodule

[rtl/constant_weight_encoder_core.sv]
// Each input transfer is range checked, then one bit position is visited per cycle
//   (at most code_length positions; a range-rejected item visits none).
// A new item is taken only after the last has gone to the output register, where
//   the result waits, so the next item is taken while it is still pending.
// Reset: synchronous active-low rst_n; afterwards the binomial table is built,
//   one entry per cycle, with in_ready held low.
// ----------------------------------------------------------------------------
// constant_weight_encoder_core
// combinadic unranking of a number into a constant weight code word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module constant_weight_encoder_core #(
  parameter int MAX_LENGTH = cwe_pkg::MAX_LENGTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cwe_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [cwe_pkg::CFG_W-1:0]   cfg_wdata,
  cwe_in_if.sink                      in_ch,
  cwe_out_if.source                   out_ch
);
  import cwe_pkg::*;

  cwe_cmd_t  cmd;
  cwe_stat_t stat;

  cwe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cwe_dp #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_value      (in_ch.value),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_code_word (out_ch.code_word),
    .out_overflow  (out_ch.overflow)
  );

endmodule
